FILE: hw/rtl/brsa_pkg.sv
package brsa_pkg;

  localparam int COORD_BITS = 16;
  localparam int WB = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int PW = 15;
  localparam int AW = 13;
  localparam int DW = 16;
  localparam int LANES = 4;
  localparam int ADDR_BITS = 4;

  localparam logic [1:0] REG_CANVAS_W = 2'd0;
  localparam logic [1:0] REG_CANVAS_H = 2'd1;
  localparam logic [1:0] REG_ALIGN    = 2'd2;
  localparam logic [1:0] REG_GUARD    = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [PW-1:0] pix_t;

  typedef struct packed {
    coord_t need_x;
    coord_t need_y;
    coord_t need_w;
    coord_t need_h;
    coord_t reuse_x;
    coord_t reuse_y;
    coord_t reuse_w;
    coord_t reuse_h;
  } in_word_t;

  typedef struct packed {
    pix_t out_x;
    pix_t out_y;
    pix_t out_w;
    pix_t out_h;
    logic is_empty;
  } out_word_t;

  typedef struct packed {
    pix_t            cnv_w;
    pix_t            cnv_h;
    logic [AW-1:0]   align_step;
    logic [AW-1:0]   guard_margin;
  } cfg_t;

  // clipped request, carried through the divider row
  typedef struct packed {
    logic                      empty;
    logic                      rfit;
    logic                      gempty;
    logic                      rok;
    pix_t                      ql;
    pix_t                      qt;
    pix_t                      qr;
    pix_t                      qb;
    pix_t                      rx;
    pix_t                      ry;
    pix_t                      rw;
    pix_t                      rh;
    logic [LANES-1:0][DW-1:0]  dvd;
    logic [LANES-1:0][AW-1:0]  rem;
  } ctx_t;

endpackage

FILE: hw/rtl/brsa_front.sv
module brsa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  brsa_pkg::cfg_t    cfg,
  input  logic              vld_i,
  input  brsa_pkg::in_word_t dat_i,
  output logic              rdy_o,
  output logic              vld_o,
  output brsa_pkg::ctx_t    dat_o,
  input  logic              rdy_i
);
  import brsa_pkg::*;

  typedef struct packed {
    logic empty;
    logic rok;
    pix_t ql;
    pix_t qt;
    pix_t qr;
    pix_t qb;
    pix_t rx;
    pix_t ry;
    pix_t rw;
    pix_t rh;
  } f1_t;

  f1_t  s1_r, s1_nxt;
  logic v1_r, v2_r, en1, en2;
  ctx_t s2_r, s2_nxt;

  function automatic pix_t clip(logic signed [WB-1:0] v, pix_t hi);
    logic signed [WB-1:0] hs;
    hs = $signed({{(WB-PW){1'b0}}, hi});
    if (v < 0) return '0;
    else if (v > hs) return hi;
    else return v[PW-1:0];
  endfunction

  assign en2   = !v2_r || rdy_i;
  assign en1   = !v1_r || en2;
  assign rdy_o = en1;
  assign vld_o = v2_r;
  assign dat_o = s2_r;

  always_comb begin
    logic signed [WB-1:0] nx, ny, nw, nh, rx, ry, rw, rh, cws, chs;
    nx  = WB'(dat_i.need_x);
    ny  = WB'(dat_i.need_y);
    nw  = WB'(dat_i.need_w);
    nh  = WB'(dat_i.need_h);
    rx  = WB'(dat_i.reuse_x);
    ry  = WB'(dat_i.reuse_y);
    rw  = WB'(dat_i.reuse_w);
    rh  = WB'(dat_i.reuse_h);
    cws = $signed({{(WB-PW){1'b0}}, cfg.cnv_w});
    chs = $signed({{(WB-PW){1'b0}}, cfg.cnv_h});
    s1_nxt.empty = (nw <= 0) || (nh <= 0) || (cfg.cnv_w == '0) ||
                   (cfg.cnv_h == '0) || (cfg.align_step == '0);
    s1_nxt.ql = clip(nx, cfg.cnv_w);
    s1_nxt.qt = clip(ny, cfg.cnv_h);
    s1_nxt.qr = clip(nx + nw, cfg.cnv_w);
    s1_nxt.qb = clip(ny + nh, cfg.cnv_h);
    s1_nxt.rok = (rw > 0) && (rh > 0) && (rx >= 0) && (ry >= 0) &&
                 (rw <= cws) && (rh <= chs) && (rx + rw <= cws) && (ry + rh <= chs);
    s1_nxt.rx = rx[PW-1:0];
    s1_nxt.ry = ry[PW-1:0];
    s1_nxt.rw = rw[PW-1:0];
    s1_nxt.rh = rh[PW-1:0];
  end

  always_comb begin
    pix_t qw, qh, gl, gt, gr, gb, gm;
    logic [DW-1:0] grs, gbs;
    gm  = PW'(cfg.guard_margin);
    qw  = s1_r.qr - s1_r.ql;
    qh  = s1_r.qb - s1_r.qt;
    gl  = (s1_r.ql > gm) ? s1_r.ql - gm : '0;
    gt  = (s1_r.qt > gm) ? s1_r.qt - gm : '0;
    grs = DW'(s1_r.qr) + DW'(cfg.guard_margin);
    gbs = DW'(s1_r.qb) + DW'(cfg.guard_margin);
    gr  = (grs > DW'(cfg.cnv_w)) ? cfg.cnv_w : grs[PW-1:0];
    gb  = (gbs > DW'(cfg.cnv_h)) ? cfg.cnv_h : gbs[PW-1:0];
    s2_nxt.empty  = s1_r.empty || (s1_r.qr <= s1_r.ql) || (s1_r.qb <= s1_r.qt);
    s2_nxt.rfit   = s1_r.rok && (s1_r.rw >= qw) && (s1_r.rh >= qh);
    s2_nxt.gempty = (gr <= gl) || (gb <= gt);
    s2_nxt.rok    = s1_r.rok;
    s2_nxt.ql     = s1_r.ql;
    s2_nxt.qt     = s1_r.qt;
    s2_nxt.qr     = s1_r.qr;
    s2_nxt.qb     = s1_r.qb;
    s2_nxt.rx     = s1_r.rx;
    s2_nxt.ry     = s1_r.ry;
    s2_nxt.rw     = s1_r.rw;
    s2_nxt.rh     = s1_r.rh;
    s2_nxt.dvd[0] = DW'(gl);
    s2_nxt.dvd[1] = DW'(gt);
    s2_nxt.dvd[2] = DW'(gr) + DW'(cfg.align_step) - DW'(1);
    s2_nxt.dvd[3] = DW'(gb) + DW'(cfg.align_step) - DW'(1);
    s2_nxt.rem    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= vld_i;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
  end

endmodule

FILE: hw/rtl/brsa_div_cell.sv
module brsa_div_cell #(
  parameter int BIT = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [brsa_pkg::AW-1:0]    align,
  input  logic                       vld_i,
  input  brsa_pkg::ctx_t             dat_i,
  output logic                       rdy_o,
  output logic                       vld_o,
  output brsa_pkg::ctx_t             dat_o,
  input  logic                       rdy_i
);
  import brsa_pkg::*;

  logic v_r, en;
  ctx_t d_r, d_nxt;

  assign en    = !v_r || rdy_i;
  assign rdy_o = en;
  assign vld_o = v_r;
  assign dat_o = d_r;

  // one restoring step on every lane
  always_comb begin
    logic [AW:0] trial;
    d_nxt = dat_i;
    for (int l = 0; l < LANES; l++) begin
      trial = {dat_i.rem[l], dat_i.dvd[l][BIT]};
      if (trial >= {1'b0, align}) d_nxt.rem[l] = AW'(trial - {1'b0, align});
      else d_nxt.rem[l] = trial[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

endmodule

FILE: hw/rtl/brsa_back.sv
module brsa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  brsa_pkg::cfg_t      cfg,
  input  logic                vld_i,
  input  brsa_pkg::ctx_t      dat_i,
  output logic                rdy_o,
  output logic                vld_o,
  output brsa_pkg::out_word_t dat_o,
  input  logic                rdy_i
);
  import brsa_pkg::*;

  typedef struct packed {
    logic empty;
    logic fit;
    pix_t ql;
    pix_t qt;
    pix_t qr;
    pix_t qb;
    pix_t rx;
    pix_t ry;
    pix_t al;
    pix_t at;
    pix_t w;
    pix_t h;
  } b1_t;

  b1_t       b1_r, b1_nxt;
  out_word_t o_r, o_nxt;
  logic      v1_r, v2_r, en1, en2;

  function automatic pix_t fit(pix_t start, pix_t stop, pix_t cap, pix_t limit,
                               pix_t pref);
    logic signed [PW+1:0] los;
    pix_t lo, hi;
    los = $signed({2'b0, stop}) - $signed({2'b0, cap});
    lo  = (los < 0) ? '0 : los[PW-1:0];
    hi  = limit - cap;
    if (start < hi) hi = start;
    if (lo > hi) return '0;
    else if (pref < lo) return lo;
    else if (pref > hi) return hi;
    else return pref;
  endfunction

  assign en2   = !v2_r || rdy_i;
  assign en1   = !v1_r || en2;
  assign rdy_o = en1;
  assign vld_o = v2_r;
  assign dat_o = o_r;

  always_comb begin
    logic [DW-1:0] cr, cb;
    pix_t al, at, ar, ab, aw, ah, w, h;
    al = PW'(dat_i.dvd[0] - DW'(dat_i.rem[0]));
    at = PW'(dat_i.dvd[1] - DW'(dat_i.rem[1]));
    cr = dat_i.dvd[2] - DW'(dat_i.rem[2]);
    cb = dat_i.dvd[3] - DW'(dat_i.rem[3]);
    ar = (cr > DW'(cfg.cnv_w)) ? cfg.cnv_w : cr[PW-1:0];
    ab = (cb > DW'(cfg.cnv_h)) ? cfg.cnv_h : cb[PW-1:0];
    aw = ar - al;
    ah = ab - at;
    if (dat_i.rfit) begin
      w = dat_i.rw;
      h = dat_i.rh;
    end else if (dat_i.rok) begin
      w = (dat_i.rw > aw) ? dat_i.rw : aw;
      h = (dat_i.rh > ah) ? dat_i.rh : ah;
      if (w > cfg.cnv_w) w = cfg.cnv_w;
      if (h > cfg.cnv_h) h = cfg.cnv_h;
    end else begin
      w = aw;
      h = ah;
    end
    b1_nxt.empty = dat_i.empty ||
                   (!dat_i.rfit && (dat_i.gempty || (ar <= al) || (ab <= at)));
    b1_nxt.fit   = dat_i.rfit || dat_i.rok;
    b1_nxt.ql    = dat_i.ql;
    b1_nxt.qt    = dat_i.qt;
    b1_nxt.qr    = dat_i.qr;
    b1_nxt.qb    = dat_i.qb;
    b1_nxt.rx    = dat_i.rx;
    b1_nxt.ry    = dat_i.ry;
    b1_nxt.al    = al;
    b1_nxt.at    = at;
    b1_nxt.w     = w;
    b1_nxt.h     = h;
  end

  always_comb begin
    o_nxt = '0;
    o_nxt.is_empty = b1_r.empty;
    if (!b1_r.empty) begin
      o_nxt.out_w = b1_r.w;
      o_nxt.out_h = b1_r.h;
      if (b1_r.fit) begin
        o_nxt.out_x = fit(b1_r.ql, b1_r.qr, b1_r.w, cfg.cnv_w, b1_r.rx);
        o_nxt.out_y = fit(b1_r.qt, b1_r.qb, b1_r.h, cfg.cnv_h, b1_r.ry);
      end else begin
        o_nxt.out_x = b1_r.al;
        o_nxt.out_y = b1_r.at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= vld_i;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) b1_r <= b1_nxt;
    if (en2) o_r <= o_nxt;
  end

endmodule

FILE: hw/rtl/backing_rect_select_align_unit.sv
// Pipeline: 2 clip stages, 16 divider cells, 2 fit stages from input word to result word.
// Throughput: one word per cycle while out_ready is high; the 16-cell alignment
//   divider row is fully pipelined.
// Reset: synchronous active-low rst_n empties the pipeline and loads the
//   registers with canvas 1920x1080, alignment 1, guard 0.
module backing_rect_select_align_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  brsa_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output brsa_pkg::out_word_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [brsa_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import brsa_pkg::*;

  cfg_t cfg_r;
  logic wr;

  logic [DW:0] dv, drdy;
  ctx_t [DW:0] dctx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cnv_w        <= PW'(1920);
      cfg_r.cnv_h        <= PW'(1080);
      cfg_r.align_step   <= AW'(1);
      cfg_r.guard_margin <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_CANVAS_W: cfg_r.cnv_w        <= pwdata[PW-1:0];
        REG_CANVAS_H: cfg_r.cnv_h        <= pwdata[PW-1:0];
        REG_ALIGN:    cfg_r.align_step   <= pwdata[AW-1:0];
        REG_GUARD:    cfg_r.guard_margin <= pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CANVAS_W: prdata = 32'(cfg_r.cnv_w);
      REG_CANVAS_H: prdata = 32'(cfg_r.cnv_h);
      REG_ALIGN:    prdata = 32'(cfg_r.align_step);
      REG_GUARD:    prdata = 32'(cfg_r.guard_margin);
      default:      prdata = '0;
    endcase
  end

  brsa_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .vld_i (in_valid),
    .dat_i (in_data),
    .rdy_o (in_ready),
    .vld_o (dv[0]),
    .dat_o (dctx[0]),
    .rdy_i (drdy[0])
  );

  for (genvar k = 0; k < DW; k++) begin : g_div
    brsa_div_cell #(.BIT(DW - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .align (cfg_r.align_step),
      .vld_i (dv[k]),
      .dat_i (dctx[k]),
      .rdy_o (drdy[k]),
      .vld_o (dv[k+1]),
      .dat_o (dctx[k+1]),
      .rdy_i (drdy[k+1])
    );
  end

  brsa_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .vld_i (dv[DW]),
    .dat_i (dctx[DW]),
    .rdy_o (drdy[DW]),
    .vld_o (out_valid),
    .dat_o (out_data),
    .rdy_i (out_ready)
  );

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.out_x == '0 && out_data.out_y == '0 &&
      out_data.out_w == '0 && out_data.out_h == '0)
    else $error("empty word carries a non-zero rectangle");

  a_nonempty_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_empty |-> out_data.out_w != '0 && out_data.out_h != '0)
    else $error("non-empty word has zero size");

  a_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_empty |->
      ({1'b0, out_data.out_x} + {1'b0, out_data.out_w} <= {1'b0, cfg_r.cnv_w}) &&
      ({1'b0, out_data.out_y} + {1'b0, out_data.out_h} <= {1'b0, cfg_r.cnv_h}))
    else $error("result leaves the canvas");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipeline stalls with the output side ready");

endmodule

FILE: tb/tb_backing_rect_select_align_unit.sv
`timescale 1ns / 100ps

module tb_backing_rect_select_align_unit;
  import brsa_pkg::*;

  localparam int LATENCY = 20;
  localparam int HOLD_LEN = 200;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  in_word_t in_data;
  logic out_valid, out_ready;
  out_word_t out_data;
  logic psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  // local copy of the registers
  int unsigned cv_w, cv_h, al_step, grd;

  out_word_t rect_q[$];
  int errors;
  bit hold_req;
  bit hold_done;

  backing_rect_select_align_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("backing_rect_select_align_unit verification failed");
    $finish;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint place_origin(longint start, longint size, longint cap,
                                          longint limit, longint pref);
    longint lo, hi;
    lo = start + size - cap;
    hi = limit - cap;
    if (lo < 0) lo = 0;
    if (start < hi) hi = start;
    if (lo > hi) return 0;
    return clampl(pref, lo, hi);
  endfunction

  function automatic out_word_t mk_rect(longint x, longint y, longint w, longint h,
                                       bit e);
    out_word_t r;
    r.out_x = pix_t'(x);
    r.out_y = pix_t'(y);
    r.out_w = pix_t'(w);
    r.out_h = pix_t'(h);
    r.is_empty = e;
    return r;
  endfunction

  function automatic out_word_t choose_backing(in_word_t d);
    longint nx, ny, nw, nh, rx, ry, rw, rh, cw, ch, a, g;
    longint ql, qt, qr, qb, qw, qh, gl, gt, gr, gb, al, at, ar, ab, aw, ah, ax, ay;
    bit ok;
    nx = d.need_x; ny = d.need_y; nw = d.need_w; nh = d.need_h;
    rx = d.reuse_x; ry = d.reuse_y; rw = d.reuse_w; rh = d.reuse_h;
    cw = cv_w; ch = cv_h; a = al_step; g = grd;
    if (nw <= 0 || nh <= 0 || cw == 0 || ch == 0 || a == 0)
      return mk_rect(0, 0, 0, 0, 1'b1);
    ql = clampl(nx, 0, cw);
    qt = clampl(ny, 0, ch);
    qr = clampl(nx + nw, 0, cw);
    qb = clampl(ny + nh, 0, ch);
    if (qr <= ql || qb <= qt) return mk_rect(0, 0, 0, 0, 1'b1);
    qw = qr - ql;
    qh = qb - qt;
    ok = rw > 0 && rh > 0 && rx >= 0 && ry >= 0 && rw <= cw && rh <= ch &&
         rx + rw <= cw && ry + rh <= ch;
    if (ok && rw >= qw && rh >= qh)
      return mk_rect(place_origin(ql, qw, rw, cw, rx), place_origin(qt, qh, rh, ch, ry),
                     rw, rh, 1'b0);
    gl = clampl(ql - g, 0, cw);
    gt = clampl(qt - g, 0, ch);
    gr = clampl(qr + g, 0, cw);
    gb = clampl(qb + g, 0, ch);
    if (gr <= gl || gb <= gt) return mk_rect(0, 0, 0, 0, 1'b1);
    al = gl / a * a;
    at = gt / a * a;
    ar = (gr + a - 1) / a * a;
    ab = (gb + a - 1) / a * a;
    if (ar > cw) ar = cw;
    if (ab > ch) ab = ch;
    aw = ar - al;
    ah = ab - at;
    ax = al;
    ay = at;
    if (aw <= 0 || ah <= 0) return mk_rect(0, 0, 0, 0, 1'b1);
    if (ok) begin
      if (rw > aw) aw = rw;
      if (rh > ah) ah = rh;
      if (aw > cw) aw = cw;
      if (ah > ch) ah = ch;
      ax = place_origin(ql, qw, aw, cw, rx);
      ay = place_origin(qt, qh, ah, ch, ry);
    end
    return mk_rect(ax, ay, aw, ah, 1'b0);
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // in_valid stays high after acceptance until the next word or an idle gap
  task automatic send_word(in_word_t d);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    rect_q.push_back(choose_backing(d));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BITS'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CANVAS_W: cv_w = val & 32'h7FFF;
      REG_CANVAS_H: cv_h = val & 32'h7FFF;
      REG_ALIGN:    al_step = val & 32'h1FFF;
      default:      grd = val & 32'h1FFF;
    endcase
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned a, int unsigned g);
    drain();
    write_reg(REG_CANVAS_W, w);
    write_reg(REG_CANVAS_H, h);
    write_reg(REG_ALIGN, a);
    write_reg(REG_GUARD, g);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic coord_t rnd_coord(int unsigned span);
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return coord_t'($urandom);
    if (p == 1) return coord_t'(-$signed($urandom_range(0, 64)));
    return coord_t'($urandom_range(0, span + 16));
  endfunction

  function automatic in_word_t rnd_word();
    in_word_t d;
    int unsigned sw, sh;
    sw = (cv_w == 0) ? 64 : cv_w;
    sh = (cv_h == 0) ? 64 : cv_h;
    d.need_x = rnd_coord(sw);
    d.need_y = rnd_coord(sh);
    d.need_w = rnd_coord(sw / 2);
    d.need_h = rnd_coord(sh / 2);
    if ($urandom_range(0, 2) == 0) begin
      d.reuse_w = coord_t'($urandom_range(1, sw));
      d.reuse_h = coord_t'($urandom_range(1, sh));
      d.reuse_x = coord_t'($urandom_range(0, sw - d.reuse_w));
      d.reuse_y = coord_t'($urandom_range(0, sh - d.reuse_h));
    end else begin
      d.reuse_x = rnd_coord(sw);
      d.reuse_y = rnd_coord(sh);
      d.reuse_w = rnd_coord(sw);
      d.reuse_h = rnd_coord(sh);
    end
    return d;
  endfunction

  task automatic mk_send(int nx, int ny, int nw, int nh, int rx, int ry, int rw, int rh);
    in_word_t d;
    d.need_x = coord_t'(nx); d.need_y = coord_t'(ny);
    d.need_w = coord_t'(nw); d.need_h = coord_t'(nh);
    d.reuse_x = coord_t'(rx); d.reuse_y = coord_t'(ry);
    d.reuse_w = coord_t'(rw); d.reuse_h = coord_t'(rh);
    send_word(d);
  endtask

  task automatic test_directed();
    mk_send(0, 0, 0, 10, 0, 0, 0, 0);
    mk_send(0, 0, 10, -1, 0, 0, 0, 0);
    mk_send(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
    mk_send(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    mk_send(-100, -100, 50, 50, 0, 0, 100, 100);
    mk_send(10, 20, 30, 40, 0, 0, 100, 100);
    mk_send(1900, 1070, 100, 100, 1800, 1000, 120, 80);
    mk_send(10, 20, 300, 400, 5, 5, 100, 100);
    mk_send(10, 20, 300, 400, 1900, 0, 100, 100);
    mk_send(0, 0, 1920, 1080, 0, 0, 1920, 1080);
    mk_send(5, 5, 5, 5, -1, 0, 10, 10);
  endtask

  task automatic test_guard_align();
    set_config(640, 480, 16, 8);
    mk_send(3, 3, 5, 5, 0, 0, 0, 0);
    mk_send(630, 470, 20, 20, 600, 400, 40, 80);
    mk_send(100, 100, 50, 50, 90, 90, 20, 20);
    set_config(100, 100, 4096, 4096);
    mk_send(10, 10, 10, 10, 0, 0, 0, 0);
    mk_send(50, 50, 1, 1, 0, 0, 30, 30);
    set_config(16384, 16384, 8191, 8191);
    mk_send(-32768, 0, 32767, 32767, 0, 0, 16384, 16384);
    mk_send(16000, 16000, 1000, 1000, 0, 0, 0, 0);
    set_config(32767, 32767, 3, 0);
    mk_send(32000, 32000, 767, 767, 32000, 0, 767, 32767);
  endtask

  task automatic test_zero_cfg();
    set_config(0, 1080, 1, 0);
    mk_send(0, 0, 10, 10, 0, 0, 0, 0);
    set_config(1920, 0, 1, 0);
    mk_send(0, 0, 10, 10, 0, 0, 0, 0);
    set_config(1920, 1080, 0, 0);
    mk_send(0, 0, 10, 10, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    repeat (n) send_word(rnd_word());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (60) send_word(rnd_word());
    drain();
    wait (hold_done);
    hold_req = 1'b0;
  endtask

  task automatic test_random_configs();
    int unsigned w, h;
    repeat (6) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 300);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 300);
      set_config(w, h, $urandom_range(0, 8191) % ($urandom_range(0, 1) ? 17 : 8192),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 9));
      test_random(150);
    end
  endtask

  // receiver: random stalls plus a long hold-off when asked
  initial begin
    int hold_cnt;
    int gap;
    out_ready = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_LEN) begin
          hold_done = 1'b1;
          hold_cnt = 0;
        end
      end else begin
        if (!hold_req) hold_done = 1'b0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          gap--;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 4) == 0) gap = gap_len();
        end
      end
    end
  end

  // result checker
  initial begin
    out_word_t exp_w;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (rect_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_data);
          errors++;
        end else begin
          exp_w = rect_q.pop_front();
          if (out_data !== exp_w) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_w, out_data);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int guard_cnt;
    errors = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cv_w = 1920; cv_h = 1080; al_step = 1; grd = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_guard_align();
    test_zero_cfg();
    set_config(1920, 1080, 1, 0);
    test_random(500);
    test_backpressure();
    set_config(256, 128, 8, 4);
    test_random(200);
    drain();
    test_random_configs();
    in_valid <= 1'b0;
    guard_cnt = 0;
    while (rect_q.size() != 0 && guard_cnt < 100000) begin
      @(posedge clk);
      guard_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && rect_q.size() == 0)
      $display("backing_rect_select_align_unit verification clean");
    else
      $display("backing_rect_select_align_unit verification failed");
    $finish;
  end

endmodule

FILE: backing_rect_select_align_unit.f
hw/rtl/brsa_pkg.sv
hw/rtl/brsa_front.sv
hw/rtl/brsa_div_cell.sv
hw/rtl/brsa_back.sv
hw/rtl/backing_rect_select_align_unit.sv
tb/tb_backing_rect_select_align_unit.sv
